@@ design/pcd_pkg.sv @@
// shared types, widths and constants for the portal plane crossing detector
package pcd_pkg;

    localparam int COORD_W         = 32;
    localparam int QUAT_W          = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int AXIS_FRAC       = 28;

    localparam int DELTA_W = COORD_W + 1;          // difference of two coordinates
    localparam int AXIS_W  = 34;                   // 2^28 - 2*(q*q + q*q) and cross terms
    localparam int QPROD_W = 2 * QUAT_W;
    localparam int LO_W    = 16;                   // low slice of a delta
    localparam int HI_W    = DELTA_W - LO_W;
    localparam int PROD_W  = AXIS_W + HI_W;        // axis times one delta slice
    localparam int PSUM_W  = PROD_W + 2;           // sum of three products
    localparam int DOT_W   = PSUM_W + LO_W;        // exact dot product

    localparam int RGT_LIMIT = 3;
    localparam int UP_LIMIT  = 6;

    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [QPROD_W-1:0] qprod_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [HI_W-1:0]    hi_part_t;
    typedef logic signed [LO_W:0]      lo_part_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    localparam axis_t AXIS_ONE  = axis_t'(1) <<< AXIS_FRAC;
    localparam dot_t  RGT_BOUND = dot_t'(RGT_LIMIT) <<< (AXIS_FRAC + COORD_FRAC_BITS);
    localparam dot_t  UP_BOUND  = dot_t'(UP_LIMIT) <<< (AXIS_FRAC + COORD_FRAC_BITS);

    localparam coord_t CENTER_RESET = coord_t'(0);
    localparam quat_t  QUAT_W_RESET = quat_t'(16384);
    localparam quat_t  QUAT_V_RESET = quat_t'(0);

    // configuration register indexes
    localparam cfg_idx_t REG_CENTER_X = cfg_idx_t'(0);
    localparam cfg_idx_t REG_CENTER_Y = cfg_idx_t'(1);
    localparam cfg_idx_t REG_CENTER_Z = cfg_idx_t'(2);
    localparam cfg_idx_t REG_QUAT_W   = cfg_idx_t'(3);
    localparam cfg_idx_t REG_QUAT_X   = cfg_idx_t'(4);
    localparam cfg_idx_t REG_QUAT_Y   = cfg_idx_t'(5);
    localparam cfg_idx_t REG_QUAT_Z   = cfg_idx_t'(6);

    // load enables of the dot product stages
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
        logic ld_dot;
    } stage_en_t;

endpackage

@@ design/portal_plane_crossing_detect.sv @@
// portal plane crossing detector top level
//
// Input channel s_*: one item is a current and a previous point, six signed
// Q15.16 coordinates. Result channel m_*: one item per input item, m_entered
// is 1 when the move went from the front to the back of the portal plane and
// the current point lies within the portal rectangle.
// Configuration channel cfg_*: register index and 32-bit data, always ready;
// center in Q15.16, rotation quaternion in Q1.14 (low 16 bits of the data).
// Write it only while no item is in flight. The rotation axes are rebuilt
// from the quaternion in two registered steps, so s_ready drops for the one
// cycle that follows a write.
// Pipeline: five register stages (delta, partial products, partial sums,
// dot product, compare). One item per cycle is sustained while m_ready is
// high and no configuration write settles; the rate is set by the fully
// pipelined multiplier array, one item per stage.
// Each stage holds when the one after it is full and stalled, so a bubble
// is filled even while m_ready is low; s_ready falls only when every stage
// is full or after a cfg write. Nothing is lost or repeated under stalls.
// Reset (aresetn low at a clock edge) empties the pipeline, loads the
// register reset values and keeps s_ready low for the first cycle after.
module portal_plane_crossing_detect (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  pcd_pkg::coord_t      s_cur_x,
    input  pcd_pkg::coord_t      s_cur_y,
    input  pcd_pkg::coord_t      s_cur_z,
    input  pcd_pkg::coord_t      s_prev_x,
    input  pcd_pkg::coord_t      s_prev_y,
    input  pcd_pkg::coord_t      s_prev_z,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_entered,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pcd_pkg::cfg_idx_t    cfg_index,
    input  logic [31:0]          cfg_data
);
    import pcd_pkg::*;

    localparam int NUM_STAGES = 5;

    // configuration registers
    coord_t center_x_reg, center_y_reg, center_z_reg;
    quat_t  quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic   settle_reg;

    // quaternion products, then axes
    qprod_t q_xx_reg, q_yy_reg, q_zz_reg, q_xy_reg, q_xz_reg, q_yz_reg;
    qprod_t q_wx_reg, q_wy_reg, q_wz_reg;
    axis_t  rgt_reg [3];
    axis_t  upv_reg [3];
    axis_t  nrm_reg [3];

    // pipeline control
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] adv;
    stage_en_t           dot_en;

    // stage 1: deltas
    delta_t dc_next [3];
    delta_t dp_next [3];
    delta_t dc_reg  [3];
    delta_t dp_reg  [3];

    dot_t dot_n_cur, dot_n_prev, dot_r_cur, dot_u_cur;
    logic entered_next;
    logic entered_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
            center_z_reg <= CENTER_RESET;
            quat_w_reg   <= QUAT_W_RESET;
            quat_x_reg   <= QUAT_V_RESET;
            quat_y_reg   <= QUAT_V_RESET;
            quat_z_reg   <= QUAT_V_RESET;
            settle_reg   <= 1'b1;
        end else begin
            settle_reg <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_X: center_x_reg <= coord_t'(cfg_data);
                    REG_CENTER_Y: center_y_reg <= coord_t'(cfg_data);
                    REG_CENTER_Z: center_z_reg <= coord_t'(cfg_data);
                    REG_QUAT_W:   quat_w_reg   <= quat_t'(cfg_data[QUAT_W-1:0]);
                    REG_QUAT_X:   quat_x_reg   <= quat_t'(cfg_data[QUAT_W-1:0]);
                    REG_QUAT_Y:   quat_y_reg   <= quat_t'(cfg_data[QUAT_W-1:0]);
                    REG_QUAT_Z:   quat_z_reg   <= quat_t'(cfg_data[QUAT_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // rotation matrix columns, rebuilt every cycle from the quaternion
    always_ff @(posedge aclk) begin
        q_xx_reg <= qprod_t'(quat_x_reg) * qprod_t'(quat_x_reg);
        q_yy_reg <= qprod_t'(quat_y_reg) * qprod_t'(quat_y_reg);
        q_zz_reg <= qprod_t'(quat_z_reg) * qprod_t'(quat_z_reg);
        q_xy_reg <= qprod_t'(quat_x_reg) * qprod_t'(quat_y_reg);
        q_xz_reg <= qprod_t'(quat_x_reg) * qprod_t'(quat_z_reg);
        q_yz_reg <= qprod_t'(quat_y_reg) * qprod_t'(quat_z_reg);
        q_wx_reg <= qprod_t'(quat_w_reg) * qprod_t'(quat_x_reg);
        q_wy_reg <= qprod_t'(quat_w_reg) * qprod_t'(quat_y_reg);
        q_wz_reg <= qprod_t'(quat_w_reg) * qprod_t'(quat_z_reg);

        rgt_reg[0] <= AXIS_ONE - ((axis_t'(q_yy_reg) + axis_t'(q_zz_reg)) <<< 1);
        rgt_reg[1] <= (axis_t'(q_xy_reg) + axis_t'(q_wz_reg)) <<< 1;
        rgt_reg[2] <= (axis_t'(q_xz_reg) - axis_t'(q_wy_reg)) <<< 1;
        upv_reg[0] <= (axis_t'(q_xy_reg) - axis_t'(q_wz_reg)) <<< 1;
        upv_reg[1] <= AXIS_ONE - ((axis_t'(q_xx_reg) + axis_t'(q_zz_reg)) <<< 1);
        upv_reg[2] <= (axis_t'(q_yz_reg) + axis_t'(q_wx_reg)) <<< 1;
        nrm_reg[0] <= (axis_t'(q_xz_reg) + axis_t'(q_wy_reg)) <<< 1;
        nrm_reg[1] <= (axis_t'(q_yz_reg) - axis_t'(q_wx_reg)) <<< 1;
        nrm_reg[2] <= AXIS_ONE - ((axis_t'(q_xx_reg) + axis_t'(q_yy_reg)) <<< 1);
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        adv[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[1] && !settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[1]) begin
                valid_reg[1] <= s_valid && s_ready;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        dc_next[0] = delta_t'(s_cur_x)  - delta_t'(center_x_reg);
        dc_next[1] = delta_t'(s_cur_y)  - delta_t'(center_y_reg);
        dc_next[2] = delta_t'(s_cur_z)  - delta_t'(center_z_reg);
        dp_next[0] = delta_t'(s_prev_x) - delta_t'(center_x_reg);
        dp_next[1] = delta_t'(s_prev_y) - delta_t'(center_y_reg);
        dp_next[2] = delta_t'(s_prev_z) - delta_t'(center_z_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            dc_reg <= dc_next;
            dp_reg <= dp_next;
        end
    end

    assign dot_en.ld_prod = adv[2];
    assign dot_en.ld_sum  = adv[3];
    assign dot_en.ld_dot  = adv[4];

    pcd_dot3 u_dot_n_cur (
        .aclk  (aclk),
        .en    (dot_en),
        .axis  (nrm_reg),
        .delta (dc_reg),
        .dot   (dot_n_cur)
    );

    pcd_dot3 u_dot_n_prev (
        .aclk  (aclk),
        .en    (dot_en),
        .axis  (nrm_reg),
        .delta (dp_reg),
        .dot   (dot_n_prev)
    );

    pcd_dot3 u_dot_r_cur (
        .aclk  (aclk),
        .en    (dot_en),
        .axis  (rgt_reg),
        .delta (dc_reg),
        .dot   (dot_r_cur)
    );

    pcd_dot3 u_dot_u_cur (
        .aclk  (aclk),
        .en    (dot_en),
        .axis  (upv_reg),
        .delta (dc_reg),
        .dot   (dot_u_cur)
    );

    // behind the plane now, in front before, bounds inclusive
    assign entered_next = (dot_n_cur < 0) && (dot_n_prev > 0)
                       && (dot_r_cur <= RGT_BOUND) && (dot_r_cur >= -RGT_BOUND)
                       && (dot_u_cur <= UP_BOUND)  && (dot_u_cur >= -UP_BOUND);

    always_ff @(posedge aclk) begin
        if (adv[NUM_STAGES]) begin
            entered_reg <= entered_next;
        end
    end

    assign m_valid   = valid_reg[NUM_STAGES];
    assign m_entered = entered_reg;

    // no item taken while the axes still reflect an old quaternion
    a_no_accept_settling: assert property (@(posedge aclk) disable iff (!aresetn)
        settle_reg |-> !(s_valid && s_ready))
        else $error("item accepted while axes settle");

    // an accepted item occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[1])
        else $error("accepted item missing from first stage");

    // a full dot stage behind a stalled output keeps its item
    a_stage4_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[NUM_STAGES-1] && !adv[NUM_STAGES]) |=>
            (valid_reg[NUM_STAGES-1] && $stable(dot_n_cur) && $stable(dot_u_cur)))
        else $error("stage four lost its item under stall");

    // a result leaves only through a handshake
    a_result_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without handshake");

endmodule

@@ design/pcd_dot3.sv @@
// three-stage exact dot product of a Q28 axis with a coordinate delta
module pcd_dot3 (
    input  logic                aclk,
    input  pcd_pkg::stage_en_t  en,
    input  pcd_pkg::axis_t      axis  [3],
    input  pcd_pkg::delta_t     delta [3],
    output pcd_pkg::dot_t       dot
);
    import pcd_pkg::*;

    prod_t lo_prod_next [3];
    prod_t hi_prod_next [3];
    prod_t lo_prod_reg  [3];
    prod_t hi_prod_reg  [3];
    psum_t lo_sum_next;
    psum_t hi_sum_next;
    psum_t lo_sum_reg;
    psum_t hi_sum_reg;
    dot_t  dot_next;
    dot_t  dot_reg;

    // each delta splits into a signed high slice and an unsigned low slice
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_prod_next[i] = prod_t'(axis[i])
                            * prod_t'(lo_part_t'({1'b0, delta[i][LO_W-1:0]}));
            hi_prod_next[i] = prod_t'(axis[i])
                            * prod_t'(hi_part_t'(delta[i][DELTA_W-1:LO_W]));
        end
    end

    assign lo_sum_next = psum_t'(lo_prod_reg[0]) + psum_t'(lo_prod_reg[1])
                       + psum_t'(lo_prod_reg[2]);
    assign hi_sum_next = psum_t'(hi_prod_reg[0]) + psum_t'(hi_prod_reg[1])
                       + psum_t'(hi_prod_reg[2]);
    assign dot_next    = (dot_t'(hi_sum_reg) <<< LO_W) + dot_t'(lo_sum_reg);

    always_ff @(posedge aclk) begin
        if (en.ld_prod) begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
        if (en.ld_sum) begin
            lo_sum_reg <= lo_sum_next;
            hi_sum_reg <= hi_sum_next;
        end
        if (en.ld_dot) begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

@@ tb/portal_crossing_checker.sv @@
`timescale 1ns / 1ps
// checker for the portal crossing detector: predicts and compares the entered flag per item
module portal_crossing_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  pcd_pkg::coord_t   s_cur_x,
    input  pcd_pkg::coord_t   s_cur_y,
    input  pcd_pkg::coord_t   s_cur_z,
    input  pcd_pkg::coord_t   s_prev_x,
    input  pcd_pkg::coord_t   s_prev_y,
    input  pcd_pkg::coord_t   s_prev_z,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_entered,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  pcd_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]       cfg_data,
    output int unsigned       fail_count,
    output int unsigned       pending_count
);
    import pcd_pkg::*;

    // wide enough that no product or sum of the exact dot products can overflow
    typedef logic signed [95:0] wide_t;

    typedef struct {
        bit          entered;
        int unsigned seq;
    } crossing_t;

    coord_t      cen_x, cen_y, cen_z;
    quat_t       q_w, q_x, q_y, q_z;
    crossing_t   crossings_q[$];
    crossing_t   oldest;
    int unsigned items_in;
    int unsigned results_out;

    function automatic wide_t axis_dot(input wide_t a0, a1, a2, d0, d1, d2);
        return a0 * d0 + a1 * d1 + a2 * d2;
    endfunction

    function automatic bit portal_entered(input coord_t cx, cy, cz, px, py, pz);
        wide_t w, x, y, z, one;
        wide_t r0, r1, r2, u0, u1, u2, n0, n1, n2;
        wide_t c0, c1, c2, p0, p1, p2;
        wide_t n_cur, n_prev, off_r, off_u, r_bound, u_bound;
        w = q_w;
        x = q_x;
        y = q_y;
        z = q_z;
        one = wide_t'(1) <<< AXIS_FRAC;
        // rotation matrix columns in Q28, used as given even when not unit
        r0 = one - 2 * (y * y + z * z);
        r1 = 2 * (x * y + w * z);
        r2 = 2 * (x * z - w * y);
        u0 = 2 * (x * y - w * z);
        u1 = one - 2 * (x * x + z * z);
        u2 = 2 * (y * z + w * x);
        n0 = 2 * (x * z + w * y);
        n1 = 2 * (y * z - w * x);
        n2 = one - 2 * (x * x + y * y);
        c0 = cx - cen_x;
        c1 = cy - cen_y;
        c2 = cz - cen_z;
        p0 = px - cen_x;
        p1 = py - cen_y;
        p2 = pz - cen_z;
        n_cur  = axis_dot(n0, n1, n2, c0, c1, c2);
        n_prev = axis_dot(n0, n1, n2, p0, p1, p2);
        off_r  = axis_dot(r0, r1, r2, c0, c1, c2);
        off_u  = axis_dot(u0, u1, u2, c0, c1, c2);
        r_bound = wide_t'(RGT_LIMIT) <<< (AXIS_FRAC + COORD_FRAC_BITS);
        u_bound = wide_t'(UP_LIMIT) <<< (AXIS_FRAC + COORD_FRAC_BITS);
        return (n_cur < 0) && (n_prev > 0)
            && (off_r <= r_bound) && (off_r >= -r_bound)
            && (off_u <= u_bound) && (off_u >= -u_bound);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            crossings_q.delete();
            cen_x = CENTER_RESET;
            cen_y = CENTER_RESET;
            cen_z = CENTER_RESET;
            q_w = QUAT_W_RESET;
            q_x = QUAT_V_RESET;
            q_y = QUAT_V_RESET;
            q_z = QUAT_V_RESET;
            items_in = 0;
            results_out = 0;
            fail_count = 0;
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_X: cen_x = cfg_data;
                    REG_CENTER_Y: cen_y = cfg_data;
                    REG_CENTER_Z: cen_z = cfg_data;
                    REG_QUAT_W:   q_w = cfg_data[QUAT_W-1:0];
                    REG_QUAT_X:   q_x = cfg_data[QUAT_W-1:0];
                    REG_QUAT_Y:   q_y = cfg_data[QUAT_W-1:0];
                    REG_QUAT_Z:   q_z = cfg_data[QUAT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                crossings_q.push_back('{portal_entered(s_cur_x, s_cur_y, s_cur_z,
                                                       s_prev_x, s_prev_y, s_prev_z),
                                        items_in});
                items_in++;
            end
            if (m_valid && m_ready) begin
                if (crossings_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with no item waiting (entered %0b)",
                                 results_out, m_entered);
                end else begin
                    oldest = crossings_q.pop_front();
                    if (m_entered !== oldest.entered) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("item %0d: entered expected %0b, got %0b",
                                     oldest.seq, oldest.entered, m_entered);
                    end
                end
                results_out++;
            end
            pending_count = crossings_q.size();
        end
    end

endmodule

@@ tb/tb_portal_plane_crossing_detect.sv @@
`timescale 1ns / 1ps
// testbench top for the portal crossing detector: clock, reset, stimulus and verdict
module tb_portal_plane_crossing_detect;
    import pcd_pkg::*;

    localparam coord_t   C_MAX       = 32'sh7FFF_FFFF;
    localparam coord_t   C_MIN       = 32'sh8000_0000;
    localparam int       UNIT        = 1 << COORD_FRAC_BITS;
    localparam cfg_idx_t REG_SPARE   = cfg_idx_t'(7);
    localparam int       LONG_HOLD   = 80;
    localparam int       PHASES      = 10;
    localparam int       PHASE_ITEMS = 123;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    coord_t      s_cur_x, s_cur_y, s_cur_z;
    coord_t      s_prev_x, s_prev_y, s_prev_z;
    logic        m_valid;
    logic        m_ready;
    logic        m_entered;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;
    int unsigned fail_count;
    int unsigned pending_count;

    // portal as seen by the item generator, in coordinate units
    real cen[3];
    real ax_r[3], ax_u[3], ax_n[3];

    bit source_steady;
    bit sink_steady;
    bit hold_off_req;

    portal_plane_crossing_detect uut (.*);

    portal_crossing_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 10);
        else return $urandom_range(20, 50);
    endfunction

    function automatic real rand_real(input real lo, input real hi);
        return lo + (hi - lo) * $itor($urandom_range(0, 1_000_000)) / 1.0e6;
    endfunction

    function automatic coord_t to_coord(input real v);
        if (v >= 2147483647.0) return C_MAX;
        if (v <= -2147483648.0) return C_MIN;
        return coord_t'($rtoi(v));
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_move(input coord_t cx, cy, cz, px, py, pz);
        int gap;
        gap = source_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cur_x  <= cx;
        s_cur_y  <= cy;
        s_cur_z  <= cz;
        s_prev_x <= px;
        s_prev_y <= py;
        s_prev_z <= pz;
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_portal(input coord_t cx, cy, cz, input quat_t qw, qx, qy, qz,
                              input bit poke_spare);
        real w, x, y, z;
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        // upper half of the data word is junk for the quaternion registers
        write_reg(REG_QUAT_W, {16'($urandom), qw});
        write_reg(REG_QUAT_X, {16'($urandom), qx});
        write_reg(REG_QUAT_Y, {16'($urandom), qy});
        write_reg(REG_QUAT_Z, {16'($urandom), qz});
        if (poke_spare) write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        cen[0] = $itor(cx);
        cen[1] = $itor(cy);
        cen[2] = $itor(cz);
        w = $itor(qw) / 16384.0;
        x = $itor(qx) / 16384.0;
        y = $itor(qy) / 16384.0;
        z = $itor(qz) / 16384.0;
        ax_r[0] = 1.0 - 2.0 * (y * y + z * z);
        ax_r[1] = 2.0 * (x * y + w * z);
        ax_r[2] = 2.0 * (x * z - w * y);
        ax_u[0] = 2.0 * (x * y - w * z);
        ax_u[1] = 1.0 - 2.0 * (x * x + z * z);
        ax_u[2] = 2.0 * (y * z + w * x);
        ax_n[0] = 2.0 * (x * z + w * y);
        ax_n[1] = 2.0 * (y * z - w * x);
        ax_n[2] = 1.0 - 2.0 * (x * x + y * y);
    endtask

    task automatic pick_random_portal();
        coord_t c[3];
        quat_t  q[4];
        real    v[4];
        real    norm;
        int     mode, i;
        mode = $urandom_range(0, 9);
        for (i = 0; i < 3; i++)
            c[i] = (mode == 0) ? ($urandom_range(0, 1) ? C_MAX : C_MIN)
                               : coord_t'($signed($urandom) >>> 2);
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            norm = 0.0;
            for (i = 0; i < 4; i++) begin
                v[i] = rand_real(-1.0, 1.0);
                norm += v[i] * v[i];
            end
            norm = $sqrt(norm);
            if (norm < 0.1) begin
                v[0] = 1.0;
                v[1] = 0.0;
                v[2] = 0.0;
                v[3] = 0.0;
                norm = 1.0;
            end
            for (i = 0; i < 4; i++) q[i] = quat_t'($rtoi(v[i] / norm * 16384.0));
        end else if (mode < 8) begin
            for (i = 0; i < 4; i++) q[i] = quat_t'($urandom);
        end else begin
            for (i = 0; i < 4; i++) q[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        set_portal(c[0], c[1], c[2], q[0], q[1], q[2], q[3], $urandom_range(0, 2) == 0);
    endtask

    // mostly front-to-back moves near the portal, some same-side moves, some noise
    task automatic send_random_move();
        int     kind, i;
        real    a, b, a2, b2, c_cur, c_prev;
        coord_t cur_pt[3], prv_pt[3];
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            send_move($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            a  = rand_real(-3.5, 3.5);
            b  = rand_real(-7.0, 7.0);
            a2 = rand_real(-8.0, 8.0);
            b2 = rand_real(-8.0, 8.0);
            c_cur  = -rand_real(0.0, 3.0);
            c_prev = rand_real(0.0, 3.0);
            if ($urandom_range(0, 9) == 0) begin
                c_cur  = -rand_real(0.0, 0.0002);
                c_prev = rand_real(0.0, 0.0002);
            end
            if (kind >= 70) begin
                if ($urandom_range(0, 1)) c_cur = -c_cur;
                else c_prev = -c_prev;
            end
            for (i = 0; i < 3; i++) begin
                cur_pt[i] = to_coord(cen[i]
                    + (a * ax_r[i] + b * ax_u[i] + c_cur * ax_n[i]) * UNIT);
                prv_pt[i] = to_coord(cen[i]
                    + (a2 * ax_r[i] + b2 * ax_u[i] + c_prev * ax_n[i]) * UNIT);
            end
            send_move(cur_pt[0], cur_pt[1], cur_pt[2], prv_pt[0], prv_pt[1], prv_pt[2]);
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending_count != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (8) @(negedge aclk);
    endtask

    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (sink_steady) begin
                m_ready <= 1'b1;
            end else begin
                stall = idle_len();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cur_x   = '0;
        s_cur_y   = '0;
        s_cur_z   = '0;
        s_prev_x  = '0;
        s_prev_y  = '0;
        s_prev_z  = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data  = '0;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        hold_off_req  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset portal: center at origin, normal along z
        send_move(0, 0, -UNIT, 0, 0, UNIT);
        send_move(0, 0, 0, 0, 0, UNIT);
        send_move(0, 0, -1, 0, 0, 0);
        send_move(3 * UNIT, 0, -1, 0, 0, 1);
        send_move(3 * UNIT + 1, 0, -1, 0, 0, 1);
        send_move(-3 * UNIT, 0, -1, 0, 0, 1);
        send_move(-3 * UNIT - 1, 0, -1, 0, 0, 1);
        send_move(0, 6 * UNIT, -1, 0, 0, 1);
        send_move(0, 6 * UNIT + 1, -1, 0, 0, 1);
        send_move(0, -6 * UNIT, -1, 0, 0, 1);
        send_move(0, -6 * UNIT - 1, -1, 0, 0, 1);
        send_move(0, 0, UNIT, 0, 0, -UNIT);
        send_move(0, 0, C_MIN, 0, 0, C_MAX);
        send_move(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_move(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_move(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX);
        s_valid <= 1'b0;
        wait_idle();

        // extreme center and a far from unit quaternion
        set_portal(C_MAX, C_MIN, C_MAX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_move(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_move(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_move(C_MAX, C_MIN, C_MAX, 0, 0, 0);
        send_move(0, 0, 0, C_MAX, C_MIN, C_MAX);
        s_valid <= 1'b0;
        wait_idle();

        set_portal(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_move(0, 0, -1, 0, 0, 1);
        send_move(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
        send_move(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT);
        send_move(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
        s_valid <= 1'b0;
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            pick_random_portal();
            source_steady = (phase == 3 || phase == 6);
            sink_steady   = (phase == 3);
            // long receiver hold while items keep coming, fills the pipeline
            if (phase == 6) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_move();
            s_valid <= 1'b0;
            wait_idle();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
design/pcd_pkg.sv
design/pcd_dot3.sv
design/portal_plane_crossing_detect.sv
tb/portal_crossing_checker.sv
tb/tb_portal_plane_crossing_detect.sv
